// File: rtl/core/dual_ultrasonic_fill_level_unit_defines.svh
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, muted while in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_ULTRASONIC_FILL_LEVEL_UNIT_DEFINES_SVH
`define DUAL_ULTRASONIC_FILL_LEVEL_UNIT_DEFINES_SVH

// same-cycle implication
`define DUFL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DUFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/dufl_pkg.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level: package
// Field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package dufl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int LEN_W      = 10;
	localparam int RANGE_W    = 11;
	localparam int TPC_W      = 8;
	localparam int TRIG_W     = 8;
	localparam int PC_W       = 20;
	localparam int PCT_W      = 7;
	localparam int NUM_W      = 17;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LEN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS  = 3'd6;

	localparam logic [LEN_W-1:0]   RST_BUCKET_LEN   = 10'd64;
	localparam logic [LEN_W-1:0]   RST_MIN_DIST     = 10'd2;
	localparam logic [RANGE_W-1:0] RST_MAX_DIST     = 11'd400;
	localparam logic [TPC_W-1:0]   RST_TICKS_PER_CM = 8'd56;
	localparam logic [TRIG_W-1:0]  RST_TRIG_TICKS   = 8'd10;
	localparam logic [PC_W-1:0]    RST_SETTLE_TICKS = 20'd50000;
	localparam logic [PC_W-1:0]    RST_PAUSE_TICKS  = 20'd300000;

	localparam logic [NUM_W-1:0]   PERCENT_SCALE    = 17'd100;

	typedef struct packed {
		logic               trig_a;
		logic               trig_b;
		logic               level_valid;
		logic [PCT_W-1:0]   fill_percent;
		logic [RANGE_W-1:0] range_a_cm;
		logic [RANGE_W-1:0] range_b_cm;
	} level_t;

endpackage

// File: rtl/core/dufl_tick_if.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level: tick channel
// One beat per sensor tick, carrying both echo pin levels.
// ----------------------------------------------------------------------------
interface dufl_tick_if;
	logic valid;
	logic ready;
	logic echo_a;
	logic echo_b;

	modport source(output valid, output echo_a, output echo_b, input ready);
	modport sink(input valid, input echo_a, input echo_b, output ready);
endinterface

// File: rtl/core/dufl_level_if.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level: result channel
// One beat per tick: trigger levels, fill percent and accepted ranges.
// ----------------------------------------------------------------------------
interface dufl_level_if;
	import dufl_pkg::*;

	logic               valid;
	logic               ready;
	logic               trig_a;
	logic               trig_b;
	logic               level_valid;
	logic [PCT_W-1:0]   fill_percent;
	logic [RANGE_W-1:0] range_a_cm;
	logic [RANGE_W-1:0] range_b_cm;

	modport source(output valid, output trig_a, output trig_b, output level_valid,
		output fill_percent, output range_a_cm, output range_b_cm, input ready);
	modport sink(input valid, input trig_a, input trig_b, input level_valid,
		input fill_percent, input range_a_cm, input range_b_cm, output ready);
endinterface

// File: rtl/core/dufl_div.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level: shared divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module dufl_div #(
	parameter int DW = 17,
	parameter int VW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic [VW:0]   trial;
	logic          take;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign take    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/dual_ultrasonic_fill_level_unit.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level unit
// Takes one beat per sensor tick and returns one result beat for it. Ordinary
// ticks (trigger, retrigger wait, echo counting, settle, pause) go from the
// accept straight to the result beat. The last settle tick of a sensor runs
// the shared restoring divider (one quotient bit per cycle, DW = larger of
// ECHO_COUNT_BITS and 17) to turn the echo count into centimetres; when it
// yields an accepted range for sensor B, the same divider then forms the fill
// percent. The tick channel is not ready from an accept until its result beat
// has been taken.
// ----------------------------------------------------------------------------
module dual_ultrasonic_fill_level_unit #(
	parameter int ECHO_COUNT_BITS = 16,
	parameter int RETRIGGER_TICKS = 15
) (
	input  logic                               clk,
	input  logic                               arst_n,
	dufl_tick_if.sink                          tick,
	dufl_level_if.source                       level,
	input  logic                               wr_en,
	input  logic [dufl_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [dufl_pkg::CFG_DATA_W-1:0]    wr_data
);
	import dufl_pkg::*;

	`include "dual_ultrasonic_fill_level_unit_defines.svh"

	localparam int DW = (ECHO_COUNT_BITS > NUM_W) ? ECHO_COUNT_BITS : NUM_W;
	localparam logic [PC_W-1:0] RETRIG_LEN    = PC_W'(RETRIGGER_TICKS);
	localparam logic [PC_W-1:0] RETRIG_PERIOD = PC_W'(2 * RETRIGGER_TICKS);

	typedef enum logic [2:0] {
		PH_TRIG,
		PH_WAIT,
		PH_COUNT,
		PH_SETTLE,
		PH_PAUSE
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIST,
		S_PREP,
		S_SCALE,
		S_PCT,
		S_OUT
	} state_t;

	logic [LEN_W-1:0]   bucket_len_q;
	logic [LEN_W-1:0]   min_dist_q;
	logic [RANGE_W-1:0] max_dist_q;
	logic [TPC_W-1:0]   tpc_q;
	logic [TRIG_W-1:0]  trig_ticks_q;
	logic [PC_W-1:0]    settle_ticks_q;
	logic [PC_W-1:0]    pause_ticks_q;

	state_t                     state_q;
	phase_t                     phase_q;
	logic                       sel_q;
	logic [PC_W-1:0]            pc_q;
	logic [ECHO_COUNT_BITS-1:0] echo_cnt_q;
	logic [RANGE_W-1:0]         range_a_q;
	logic [RANGE_W-1:0]         range_b_q;
	logic [PCT_W-1:0]           pct_q;
	logic [LEN_W-1:0]           diff_q;
	level_t                     out_q;

	logic            accept;
	logic            echo_sel;
	logic [PC_W-1:0] pc_inc;
	logic            tick_trig;
	logic            settle_hit;
	logic            div_start;
	logic [DW-1:0]   div_dividend;
	logic [LEN_W-1:0] div_divisor;
	logic            div_done;
	logic [DW-1:0]   div_quot;
	logic            dist_reject;
	logic [RANGE_W:0] range_sum;
	logic [RANGE_W-1:0] avg;
	logic [LEN_W-1:0] avg_clamped;

	assign accept     = tick.valid && tick.ready;
	assign echo_sel   = sel_q ? tick.echo_b : tick.echo_a;
	assign pc_inc     = pc_q + 1'b1;
	assign settle_hit = (phase_q == PH_SETTLE) && (pc_inc >= settle_ticks_q);
	assign tick_trig  = (phase_q == PH_TRIG) ||
		((phase_q == PH_WAIT) && !((pc_q == '0) && echo_sel) && (pc_q < RETRIG_LEN));

	assign range_sum   = {1'b0, range_a_q} + {1'b0, range_b_q};
	assign avg         = range_sum[RANGE_W:1];
	assign avg_clamped = (avg > {1'b0, bucket_len_q}) ? bucket_len_q : avg[LEN_W-1:0];

	assign div_start    = (state_q == S_IDLE && accept && settle_hit) || (state_q == S_SCALE);
	assign div_dividend = (state_q == S_SCALE) ?
		DW'(NUM_W'(diff_q) * PERCENT_SCALE) : DW'(echo_cnt_q);
	assign div_divisor  = (state_q == S_SCALE) ? bucket_len_q :
		((tpc_q == '0) ? LEN_W'(1) : LEN_W'(tpc_q));
	assign dist_reject  = (div_quot <= DW'(min_dist_q)) || (div_quot > DW'(max_dist_q));

	dufl_div #(
		.DW(DW),
		.VW(LEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_len_q   <= RST_BUCKET_LEN;
			min_dist_q     <= RST_MIN_DIST;
			max_dist_q     <= RST_MAX_DIST;
			tpc_q          <= RST_TICKS_PER_CM;
			trig_ticks_q   <= RST_TRIG_TICKS;
			settle_ticks_q <= RST_SETTLE_TICKS;
			pause_ticks_q  <= RST_PAUSE_TICKS;
		end else if (wr_en) begin
			case (wr_index)
				REG_BUCKET_LEN:   bucket_len_q   <= wr_data[LEN_W-1:0];
				REG_MIN_DIST:     min_dist_q     <= wr_data[LEN_W-1:0];
				REG_MAX_DIST:     max_dist_q     <= wr_data[RANGE_W-1:0];
				REG_TICKS_PER_CM: tpc_q          <= wr_data[TPC_W-1:0];
				REG_TRIG_TICKS:   trig_ticks_q   <= wr_data[TRIG_W-1:0];
				REG_SETTLE_TICKS: settle_ticks_q <= wr_data;
				REG_PAUSE_TICKS:  pause_ticks_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_TRIG;
			sel_q      <= 1'b0;
			pc_q       <= '0;
			echo_cnt_q <= '0;
			range_a_q  <= '0;
			range_b_q  <= '0;
			pct_q      <= '0;
			diff_q     <= '0;
			out_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_q.trig_a       <= tick_trig && !sel_q;
						out_q.trig_b       <= tick_trig && sel_q;
						out_q.level_valid  <= 1'b0;
						out_q.fill_percent <= pct_q;
						out_q.range_a_cm   <= range_a_q;
						out_q.range_b_cm   <= range_b_q;
						state_q            <= S_OUT;
						case (phase_q)
							PH_WAIT: begin
								if ((pc_q == '0) && echo_sel) begin
									phase_q    <= PH_COUNT;
									pc_q       <= '0;
									echo_cnt_q <= ECHO_COUNT_BITS'(1);
								end else begin
									pc_q <= (pc_inc >= RETRIG_PERIOD) ? '0 : pc_inc;
								end
							end
							PH_COUNT: begin
								if (echo_sel) begin
									if (echo_cnt_q != '1) begin
										echo_cnt_q <= echo_cnt_q + 1'b1;
									end
								end else begin
									phase_q <= PH_SETTLE;
									pc_q    <= '0;
								end
							end
							PH_SETTLE: begin
								pc_q <= pc_inc;
								if (settle_hit) begin
									state_q <= S_DIST;
								end
							end
							PH_PAUSE: begin
								if (pc_inc >= pause_ticks_q) begin
									phase_q <= PH_TRIG;
									pc_q    <= '0;
								end else begin
									pc_q <= pc_inc;
								end
							end
							default: begin
								if (pc_inc >= PC_W'(trig_ticks_q)) begin
									phase_q <= PH_WAIT;
									pc_q    <= '0;
								end else begin
									pc_q <= pc_inc;
								end
							end
						endcase
					end
				end
				S_DIST: begin
					if (div_done) begin
						echo_cnt_q <= '0;
						pc_q       <= '0;
						if (dist_reject) begin
							phase_q <= PH_TRIG;
							state_q <= S_OUT;
						end else if (!sel_q) begin
							range_a_q        <= div_quot[RANGE_W-1:0];
							out_q.range_a_cm <= div_quot[RANGE_W-1:0];
							sel_q            <= 1'b1;
							phase_q          <= PH_TRIG;
							state_q          <= S_OUT;
						end else begin
							range_b_q <= div_quot[RANGE_W-1:0];
							state_q   <= S_PREP;
						end
					end
				end
				S_PREP: begin
					diff_q  <= bucket_len_q - avg_clamped;
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_PCT;
				end
				S_PCT: begin
					if (div_done) begin
						pct_q              <= (bucket_len_q == '0) ? '0 : div_quot[PCT_W-1:0];
						out_q.fill_percent <= (bucket_len_q == '0) ? '0 : div_quot[PCT_W-1:0];
						out_q.level_valid  <= 1'b1;
						out_q.range_b_cm   <= range_b_q;
						sel_q              <= 1'b0;
						phase_q            <= PH_PAUSE;
						state_q            <= S_OUT;
					end
				end
				S_OUT: begin
					if (level.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready         = (state_q == S_IDLE);
	assign level.valid        = (state_q == S_OUT);
	assign level.trig_a       = out_q.trig_a;
	assign level.trig_b       = out_q.trig_b;
	assign level.level_valid  = out_q.level_valid;
	assign level.fill_percent = out_q.fill_percent;
	assign level.range_a_cm   = out_q.range_a_cm;
	assign level.range_b_cm   = out_q.range_b_cm;

	`DUFL_ASSERT_NOW(a_ready_excl_valid, tick.ready, !level.valid, "tick ready while result pending")
	`DUFL_ASSERT_NEXT(a_busy_after_accept, tick.valid && tick.ready, !tick.ready, "accepted twice")
	`DUFL_ASSERT_NOW(a_one_trigger, level.valid, !(level.trig_a && level.trig_b), "both triggers high")
	`DUFL_ASSERT_NOW(a_pct_range, level.valid && level.level_valid, level.fill_percent <= 7'd100, "fill percent above 100")

endmodule

// File: tb/tb_dual_ultrasonic_fill_level_unit.sv
// ----------------------------------------------------------------------------
// Dual ultrasonic fill level unit: testbench
// Drives sensor ticks with echo waveforms that follow the unit's own
// measurement cycle, so that pulses of chosen length hit the retrigger window.
// A cycle-free model of the unit predicts the level beat for every tick. The
// stimulus covers zero and extreme register values, rejected and saturated
// echoes, randomized settings with random stalls on both channels, and a long
// back-pressure hold-off.
// ----------------------------------------------------------------------------
module tb_dual_ultrasonic_fill_level_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dufl_pkg::*;

	localparam int RETRIG       = 15;
	localparam int CYCLE_LIMIT  = 10000000;
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD    = 500;
	localparam int RAND_TICKS   = 1350;
	localparam logic [15:0] ECHO_MAX = 16'hFFFF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum logic [2:0] {
		PH_TRIG,
		PH_WAIT,
		PH_COUNT,
		PH_SETTLE,
		PH_PAUSE
	} meas_phase_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	dufl_tick_if  tick_ch ();
	dufl_level_if level_ch ();

	dual_ultrasonic_fill_level_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.level    (level_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	logic [LEN_W-1:0]   cfg_len;
	logic [LEN_W-1:0]   cfg_min;
	logic [RANGE_W-1:0] cfg_max;
	logic [TPC_W-1:0]   cfg_tpc;
	logic [TRIG_W-1:0]  cfg_trig;
	logic [PC_W-1:0]    cfg_settle;
	logic [PC_W-1:0]    cfg_pause;

	meas_phase_t        st_phase;
	logic               st_sel;
	logic [PC_W-1:0]    st_cnt;
	logic [15:0]        st_echo;
	logic [RANGE_W-1:0] st_range_a;
	logic [RANGE_W-1:0] st_range_b;
	logic [PCT_W-1:0]   st_pct;

	level_t expected_levels[$];
	level_t got_beat;
	level_t want_beat;
	int     errors;
	int     beat_idx;
	int     ticks_sent;
	int     cycle_count;
	int     hold_left;
	bit     idle_en;
	bit     hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_ultrasonic_fill_level_unit: mismatch");
			$finish;
		end
	end

	task automatic predict_level_beat(input logic ea, input logic eb, output level_t beat);
		logic        echo;
		logic        trig;
		logic        lv;
		logic [15:0] range_cm;
		int          div;
		int          avg;
		echo = st_sel ? eb : ea;
		trig = 1'b0;
		lv   = 1'b0;
		case (st_phase)
			PH_WAIT: begin
				if (st_cnt == 0 && echo) begin
					st_phase = PH_COUNT;
					st_cnt   = '0;
					st_echo  = 16'd1;
				end else begin
					trig = (st_cnt < RETRIG);
					st_cnt++;
					if (st_cnt >= 2 * RETRIG)
						st_cnt = '0;
				end
			end
			PH_COUNT: begin
				if (echo) begin
					if (st_echo != ECHO_MAX)
						st_echo++;
				end else begin
					st_phase = PH_SETTLE;
					st_cnt   = '0;
				end
			end
			PH_SETTLE: begin
				st_cnt++;
				if (st_cnt >= cfg_settle) begin
					div      = (cfg_tpc == 0) ? 1 : int'(cfg_tpc);
					range_cm = 16'(int'(st_echo) / div);
					st_echo  = '0;
					st_cnt   = '0;
					if (range_cm <= cfg_min || range_cm > cfg_max) begin
						st_phase = PH_TRIG;
					end else if (!st_sel) begin
						st_range_a = range_cm[RANGE_W-1:0];
						st_sel     = 1'b1;
						st_phase   = PH_TRIG;
					end else begin
						st_range_b = range_cm[RANGE_W-1:0];
						if (cfg_len == 0) begin
							st_pct = '0;
						end else begin
							avg = (int'(st_range_a) + int'(st_range_b)) / 2;
							if (avg > int'(cfg_len))
								avg = int'(cfg_len);
							st_pct = PCT_W'((int'(cfg_len) - avg) * 100 / int'(cfg_len));
						end
						lv       = 1'b1;
						st_sel   = 1'b0;
						st_phase = PH_PAUSE;
					end
				end
			end
			PH_PAUSE: begin
				st_cnt++;
				if (st_cnt >= cfg_pause) begin
					st_phase = PH_TRIG;
					st_cnt   = '0;
				end
			end
			default: begin
				trig = 1'b1;
				st_cnt++;
				if (st_cnt >= cfg_trig) begin
					st_phase = PH_WAIT;
					st_cnt   = '0;
				end
			end
		endcase
		beat.trig_a       = !st_sel && trig;
		beat.trig_b       = st_sel && trig;
		beat.level_valid  = lv;
		beat.fill_percent = st_pct;
		beat.range_a_cm   = st_range_a;
		beat.range_b_cm   = st_range_b;
	endtask

	task automatic send_tick(input logic ea, input logic eb);
		level_t beat;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		predict_level_beat(ea, eb, beat);
		expected_levels.push_back(beat);
		ticks_sent++;
		tick_ch.valid  <= 1'b1;
		tick_ch.echo_a <= ea;
		tick_ch.echo_b <= eb;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
	endtask

	// drive the selected sensor, noise on the other
	task automatic send_sel(input logic e);
		logic r;
		r = 1'($urandom_range(0, 1));
		if (st_sel)
			send_tick(r, e);
		else
			send_tick(e, r);
	endtask

	task automatic wait_drained();
		tick_ch.valid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic [CFG_DATA_W-1:0] d;
		logic [CFG_DATA_W-1:0] mask;
		int                    w;
		if (idx == REG_MAX_DIST)
			w = RANGE_W;
		else if (idx == REG_TICKS_PER_CM || idx == REG_TRIG_TICKS)
			w = TPC_W;
		else if (idx >= REG_SETTLE_TICKS)
			w = PC_W;
		else
			w = LEN_W;
		mask = (w == PC_W) ? '1 : CFG_DATA_W'((1 << w) - 1);
		d    = (CFG_DATA_W'($urandom()) & ~mask) | (CFG_DATA_W'(value) & mask);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= d;
		case (idx)
			REG_BUCKET_LEN:   cfg_len    = d[LEN_W-1:0];
			REG_MIN_DIST:     cfg_min    = d[LEN_W-1:0];
			REG_MAX_DIST:     cfg_max    = d[RANGE_W-1:0];
			REG_TICKS_PER_CM: cfg_tpc    = d[TPC_W-1:0];
			REG_TRIG_TICKS:   cfg_trig   = d[TRIG_W-1:0];
			REG_SETTLE_TICKS: cfg_settle = d;
			REG_PAUSE_TICKS:  cfg_pause  = d;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int len, input int min_cm, input int max_cm, input int tpc,
			input int trig, input int settle, input int pause);
		wait_drained();
		set_reg(REG_BUCKET_LEN, len);
		set_reg(REG_MIN_DIST, min_cm);
		set_reg(REG_MAX_DIST, max_cm);
		set_reg(REG_TICKS_PER_CM, tpc);
		set_reg(REG_TRIG_TICKS, trig);
		set_reg(REG_SETTLE_TICKS, settle);
		set_reg(REG_PAUSE_TICKS, pause);
	endtask

	function automatic int echo_len_for(input int range_cm);
		int div;
		div = (cfg_tpc == 0) ? 1 : int'(cfg_tpc);
		return range_cm * div + $urandom_range(0, div - 1);
	endfunction

	// one echo pulse of hi_len ticks on the selected sensor, through settle
	task automatic measure(input int hi_len, input bit noisy);
		while (!(st_phase == PH_WAIT && st_cnt == 0))
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			send_sel(1'b0);
			while (!(st_phase == PH_WAIT && st_cnt == 0))
				send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		for (int i = 0; i < hi_len; i++)
			send_sel(noisy ? ($urandom_range(0, 7) != 0) : 1'b1);
		while (st_phase == PH_COUNT)
			send_sel(1'b0);
		while (st_phase == PH_SETTLE)
			send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic random_round();
		int len;
		int min_cm;
		int max_cm;
		int hi;
		int r;
		int n;
		case ($urandom_range(0, 19))
			0:       len = 0;
			1:       len = $urandom_range(41, 1023);
			default: len = $urandom_range(1, 40);
		endcase
		min_cm = $urandom_range(0, 4);
		max_cm = ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(min_cm, 2 * len + 10);
		if (max_cm > 2047)
			max_cm = 2047;
		configure(len, min_cm, max_cm, $urandom_range(0, 3), $urandom_range(0, 4),
			$urandom_range(0, 4), $urandom_range(0, 4));
		repeat ($urandom_range(2, 8)) begin
			hi = 2 * len + 8;
			if (hi > 300)
				hi = 300;
			if (hi > max_cm)
				hi = max_cm;
			if (min_cm + 1 <= hi && $urandom_range(0, 4) != 0)
				r = $urandom_range(min_cm + 1, hi);
			else if (min_cm > 0 && $urandom_range(0, 1) == 1)
				r = $urandom_range(0, min_cm);
			else
				r = max_cm + $urandom_range(1, 4);
			n = echo_len_for(r);
			if (n < 1)
				n = 1;
			measure(n, $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic test_reset_defaults();
		repeat (45) send_sel(1'b0);
	endtask

	task automatic test_zero_settings();
		configure(0, 0, 2047, 0, 0, 0, 0);
		measure(3, 1'b0);
		measure(5, 1'b0);
		measure(1, 1'b0);
		measure(2, 1'b0);
	endtask

	task automatic test_extremes();
		configure(1023, 1023, 2047, 1, 255, 2, 2);
		measure(1023, 1'b0);
		measure(1024, 1'b0);
		measure(2048, 1'b0);
		measure(2047, 1'b0);
		configure(1023, 0, 2047, 255, 1, 3, 3);
		measure(echo_len_for(1), 1'b0);
		measure(echo_len_for(2), 1'b0);
		configure(1, 0, 0, 1, 1, 1, 1);
		measure(1, 1'b0);
		measure(2, 1'b0);
		configure(1, 0, 5, 2, 2, 1, 1);
		measure(echo_len_for(1), 1'b0);
		measure(echo_len_for(3), 1'b0);
		configure(7, 5, 5, 1, 3, 1, 1);
		measure(5, 1'b0);
		measure(6, 1'b0);
		configure(7, 2, 400, 1, 3, 1, 1);
		measure(3, 1'b0);
		measure(4, 1'b0);
		configure(7, 2, 400, 1, 255, 1048575, 1048575);
		repeat (20) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_unknown_index();
		configure(20, 1, 100, 2, 2, 1, 1);
		repeat (3) set_reg(REG_UNUSED, $urandom());
		measure(echo_len_for(6), 1'b0);
		measure(echo_len_for(9), 1'b0);
	endtask

	task automatic test_echo_saturation();
		idle_en = 1'b0;
		configure(64, 2, 400, 1, 1, 0, 0);
		measure(65600, 1'b0);
		measure(10, 1'b0);
		measure(20, 1'b0);
		idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		configure(16, 1, 64, 1, 2, 2, 2);
		hold_req = 1'b1;
		repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		measure(8, 1'b0);
		measure(12, 1'b0);
	endtask

	task automatic test_random_settings();
		int tick_goal;
		tick_goal = ticks_sent + RAND_TICKS;
		while (ticks_sent < tick_goal)
			random_round();
	endtask

	task automatic test_steady_stream();
		idle_en = 1'b0;
		repeat (3) random_round();
	endtask

	always @(posedge clk) begin
		if (arst_n && level_ch.valid && level_ch.ready) begin
			got_beat.trig_a       = level_ch.trig_a;
			got_beat.trig_b       = level_ch.trig_b;
			got_beat.level_valid  = level_ch.level_valid;
			got_beat.fill_percent = level_ch.fill_percent;
			got_beat.range_a_cm   = level_ch.range_a_cm;
			got_beat.range_b_cm   = level_ch.range_b_cm;
			if (expected_levels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("beat %0d: no tick outstanding, got %p", beat_idx, got_beat);
			end else begin
				want_beat = expected_levels.pop_front();
				if (got_beat.trig_a !== want_beat.trig_a
						|| got_beat.trig_b !== want_beat.trig_b
						|| got_beat.level_valid !== want_beat.level_valid
						|| got_beat.fill_percent !== want_beat.fill_percent
						|| got_beat.range_a_cm !== want_beat.range_a_cm
						|| got_beat.range_b_cm !== want_beat.range_b_cm) begin
					errors++;
					if (errors <= 10)
						$display("beat %0d: expected %p, got %p", beat_idx, want_beat, got_beat);
				end
			end
			beat_idx++;
		end
	end

	initial begin
		level_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				level_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
				level_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 18) - 1;
				level_ch.ready <= 1'b0;
			end else begin
				level_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n         <= 1'b0;
		wr_en          <= 1'b0;
		wr_index       <= '0;
		wr_data        <= '0;
		tick_ch.valid  <= 1'b0;
		tick_ch.echo_a <= 1'b0;
		tick_ch.echo_b <= 1'b0;
		cfg_len    = RST_BUCKET_LEN;
		cfg_min    = RST_MIN_DIST;
		cfg_max    = RST_MAX_DIST;
		cfg_tpc    = RST_TICKS_PER_CM;
		cfg_trig   = RST_TRIG_TICKS;
		cfg_settle = RST_SETTLE_TICKS;
		cfg_pause  = RST_PAUSE_TICKS;
		st_phase   = PH_TRIG;
		st_sel     = 1'b0;
		st_cnt     = '0;
		st_echo    = '0;
		st_range_a = '0;
		st_range_b = '0;
		st_pct     = '0;
		idle_en    = 1'b1;
		hold_req   = 1'b0;
		hold_left  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_settings();
		test_extremes();
		test_unknown_index();
		test_echo_saturation();
		test_backpressure();
		test_random_settings();
		test_steady_stream();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("dual_ultrasonic_fill_level_unit: match");
		else
			$display("dual_ultrasonic_fill_level_unit: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dufl_pkg.sv
rtl/core/dufl_tick_if.sv
rtl/core/dufl_level_if.sv
rtl/core/dufl_div.sv
rtl/core/dual_ultrasonic_fill_level_unit.sv
tb/tb_dual_ultrasonic_fill_level_unit.sv
